// ----- design/phbe_pkg.sv -----
// Package for the PS/2 host bit engine: command codes, word types and
// frame constants. No dependencies; phbe_core and ps2_host_bit_engine_top import it.
package phbe_pkg;

  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SHIFT_W = 16;
  localparam int unsigned FRAME_W = 11;
  localparam int unsigned CFG_W   = 8;

  localparam logic [CNT_W-1:0] FRAME_BITS  = 4'd11;
  localparam logic [CNT_W-1:0] START_COUNT = 4'd12;
  localparam logic [CFG_W-1:0] RELOAD_RST  = 8'd12;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_EDGE       = 2'd1,
    CMD_START_SEND = 2'd2,
    CMD_START_RECV = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic               data_in;
    logic [FRAME_W-1:0] send_frame;
  } item_t;

  typedef struct packed {
    logic               data_out;
    logic               data_drive;
    logic               clock_hold;
    logic               busy_res;
    logic               done_res;
    logic [FRAME_W-1:0] received_frame;
    logic               timed_out;
  } result_t;

endpackage

// ----- design/phbe_in_if.sv -----
// Input channel of the PS/2 host bit engine: valid/ready plus one item word.
// Standalone; field widths follow the package constants by value.
interface phbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        data_in;
  logic [10:0] send_frame;

  modport source (output valid, command, data_in, send_frame, input ready);
  modport sink   (input valid, command, data_in, send_frame, output ready);
endinterface

// ----- design/phbe_out_if.sv -----
// Result channel of the PS/2 host bit engine: valid/ready plus one result word.
// Standalone; field widths follow the package constants by value.
interface phbe_out_if;
  logic        valid;
  logic        ready;
  logic        data_out;
  logic        data_drive;
  logic        clock_hold;
  logic        busy_res;
  logic        done_res;
  logic [10:0] received_frame;
  logic        timed_out;

  modport source (output valid, data_out, data_drive, clock_hold, busy_res, done_res,
                  received_frame, timed_out, input ready);
  modport sink   (input valid, data_out, data_drive, clock_hold, busy_res, done_res,
                  received_frame, timed_out, output ready);
endinterface

// ----- design/phbe_cfg_if.sv -----
// Configuration write channel of the PS/2 host bit engine.
// Carries the timeout reload word with valid/ready; standalone.
interface phbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- design/phbe_core.sv -----
// Transfer state of the PS/2 host bit engine and its one-word update logic.
// Depends on phbe_pkg for the item and result words and the frame constants.
module phbe_core #(
  parameter int unsigned TIMEOUT_WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  phbe_pkg::item_t        item_i,
  input  logic [7:0]             reload_i,
  output phbe_pkg::result_t      result_o
);
  import phbe_pkg::*;

  logic [CNT_W-1:0]         bit_count_q, bit_count_d, bit_count_dec;
  logic [SHIFT_W-1:0]       shift_reg_q, shift_reg_d, shift_rx;
  logic [TIMEOUT_WIDTH-1:0] timeout_q, timeout_d, reload;
  logic                     send_mode_q, send_mode_d;
  logic                     drive_data_q, drive_data_d;
  logic                     hold_clock_q, hold_clock_d;
  logic                     level_q, level_d;
  logic                     done;
  logic [FRAME_W-1:0]       rx_frame;

  assign reload        = TIMEOUT_WIDTH'(reload_i);
  assign bit_count_dec = bit_count_q - 1'b1;
  assign shift_rx      = {item_i.data_in, shift_reg_q[SHIFT_W-1:1]};

  always_comb begin
    bit_count_d  = bit_count_q;
    shift_reg_d  = shift_reg_q;
    timeout_d    = timeout_q;
    send_mode_d  = send_mode_q;
    drive_data_d = drive_data_q;
    hold_clock_d = hold_clock_q;
    level_d      = level_q;
    done         = 1'b0;
    rx_frame     = '0;
    unique case (item_i.command)
      CMD_TICK: begin
        if (bit_count_q != '0 && bit_count_q < START_COUNT) begin
          if (send_mode_q && bit_count_q == FRAME_BITS && timeout_q < reload) begin
            hold_clock_d = 1'b0;
          end
          if (timeout_q != '0) begin
            timeout_d = timeout_q - 1'b1;
          end
        end
      end
      CMD_EDGE: begin
        if (bit_count_q != '0 && bit_count_q <= START_COUNT) begin
          bit_count_d = bit_count_dec;
          if (send_mode_q) begin
            if (bit_count_dec != '0) begin
              level_d     = shift_reg_q[0];
              shift_reg_d = {1'b0, shift_reg_q[SHIFT_W-1:1]};
              if (bit_count_dec == FRAME_BITS) begin
                drive_data_d = 1'b1;
              end else if (bit_count_dec == CNT_W'(1)) begin
                drive_data_d = 1'b0;
              end
            end else begin
              hold_clock_d = 1'b1;
              done         = 1'b1;
            end
          end else begin
            shift_reg_d = shift_rx;
            if (bit_count_dec == CNT_W'(1)) begin
              hold_clock_d = 1'b1;
              bit_count_d  = '0;
              done         = 1'b1;
              rx_frame     = shift_rx[SHIFT_W-1 -: FRAME_W];
            end
          end
          timeout_d = reload;
        end
      end
      CMD_START_SEND: begin
        send_mode_d  = 1'b1;
        shift_reg_d  = SHIFT_W'(item_i.send_frame);
        bit_count_d  = START_COUNT;
        timeout_d    = reload;
        hold_clock_d = 1'b1;
        drive_data_d = 1'b0;
      end
      CMD_START_RECV: begin
        send_mode_d  = 1'b0;
        shift_reg_d  = '0;
        bit_count_d  = START_COUNT;
        timeout_d    = reload;
        hold_clock_d = 1'b0;
        drive_data_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.data_out       = drive_data_d & level_d;
    result_o.data_drive     = drive_data_d;
    result_o.clock_hold     = hold_clock_d;
    result_o.busy_res       = (bit_count_d != '0);
    result_o.done_res       = done;
    result_o.received_frame = rx_frame;
    result_o.timed_out      = (bit_count_d != '0) && (bit_count_d < START_COUNT) &&
                              (timeout_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q  <= '0;
      shift_reg_q  <= '0;
      timeout_q    <= '0;
      send_mode_q  <= 1'b0;
      drive_data_q <= 1'b0;
      hold_clock_q <= 1'b0;
      level_q      <= 1'b0;
    end else if (fire_i) begin
      bit_count_q  <= bit_count_d;
      shift_reg_q  <= shift_reg_d;
      timeout_q    <= timeout_d;
      send_mode_q  <= send_mode_d;
      drive_data_q <= drive_data_d;
      hold_clock_q <= hold_clock_d;
      level_q      <= level_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= START_COUNT)
    else $error("bit count above start value");

  a_drive_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_data_q |-> send_mode_q)
    else $error("data driven outside send mode");

  a_start_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.command == CMD_START_SEND |=>
      bit_count_q == START_COUNT && send_mode_q && hold_clock_q)
    else $error("start send did not arm the transfer");

  a_rx_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && done && !send_mode_q |=> bit_count_q == '0 && hold_clock_q)
    else $error("receive completion left the engine busy");

endmodule

// ----- design/ps2_host_bit_engine_top.sv -----
// An accepted word waits in the input register until the result register is free to take its result.
// Throughput: one word per cycle; each stage advances whenever the next is free.
// Stages: an input register, then the state update into the result register.
// Reset (rst_ni low, asynchronous) empties both stages, clears the transfer
// state and sets the timeout reload to 12. The config port is always ready.
// Depends on phbe_pkg, phbe_in_if, phbe_out_if, phbe_cfg_if and phbe_core.
module ps2_host_bit_engine_top #(
  parameter int unsigned TIMEOUT_WIDTH = 8
) (
  input logic         clk_i,
  input logic         rst_ni,
  phbe_in_if.sink     in_ch,
  phbe_out_if.source  out_ch,
  phbe_cfg_if.sink    cfg_ch
);
  import phbe_pkg::*;

  logic             in_vld_q;
  item_t            in_item_q;
  logic             out_vld_q;
  result_t          result_q;
  result_t          result_d;
  logic [CFG_W-1:0] reload_q;
  logic             advance;

  assign advance      = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !in_vld_q || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= RELOAD_RST;
    end else if (cfg_ch.valid) begin
      reload_q <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_q.command    <= cmd_e'(in_ch.command);
      in_item_q.data_in    <= in_ch.data_in;
      in_item_q.send_frame <= in_ch.send_frame;
    end
  end

  phbe_core #(
    .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .reload_i (reload_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.data_out       = result_q.data_out;
  assign out_ch.data_drive     = result_q.data_drive;
  assign out_ch.clock_hold     = result_q.clock_hold;
  assign out_ch.busy_res       = result_q.busy_res;
  assign out_ch.done_res       = result_q.done_res;
  assign out_ch.received_frame = result_q.received_frame;
  assign out_ch.timed_out      = result_q.timed_out;

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q)
    else $error("input stage dropped a pending word");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result register not filled after advance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !out_vld_q || out_ch.ready)
    else $error("advance would overwrite an untaken result");

endmodule
